@@ rtl/rrtq_pkg.sv @@
`timescale 1ns / 1ps

package rrtq_pkg;

	localparam int KIND_W    = 2;
	localparam int PID_PORT_W = 16;
	localparam int STACK_W   = 48;
	localparam int ST_W      = 2;
	localparam int CNT_W     = 32;
	localparam int TOTAL_W   = 5;

	localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SWITCH = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TERM   = 2'd2;

	localparam logic [ST_W-1:0] ST_CREATED  = 2'd0;
	localparam logic [ST_W-1:0] ST_RUNNABLE = 2'd1;
	localparam logic [ST_W-1:0] ST_RUNNING  = 2'd2;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SWITCH,
		OP_TERM,
		OP_NONE
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} cmd_ctl_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_SW_WAIT,
		S_SW_RD2,
		S_SW_WAIT2,
		S_TM_SRCH,
		S_TM_MOVE,
		S_HD_RD,
		S_HD_OUT
	} bk_state_t;

endpackage

@@ rtl/rrtq_ram.sv @@
`timescale 1ns / 1ps

module rrtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/rrtq_front.sv @@
`timescale 1ns / 1ps

module rrtq_front #(
	parameter int PID_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [rrtq_pkg::KIND_W-1:0]    kind,
	input  logic [rrtq_pkg::PID_PORT_W-1:0] task_pid,
	input  logic [rrtq_pkg::STACK_W-1:0]   kernel_stack,
	output rrtq_pkg::cmd_ctl_t             cmd_ctl,
	output logic [PID_BITS-1:0]            cmd_pid,
	output logic [rrtq_pkg::STACK_W-1:0]   cmd_stack,
	input  logic                           cmd_pop
);

	localparam int QD = 2;

	rrtq_pkg::op_t                 op_q    [QD];
	logic [PID_BITS-1:0]           pid_q   [QD];
	logic [rrtq_pkg::STACK_W-1:0]  stack_q [QD];
	logic                          wr_ptr_q;
	logic                          rd_ptr_q;
	logic [1:0]                    cnt_q;

	rrtq_pkg::op_t                                 dec_op;
	logic [PID_BITS+rrtq_pkg::PID_PORT_W-1:0]      pid_ext;
	logic                                          push;
	logic                                          pop;

	always_comb begin
		case (kind)
			rrtq_pkg::KIND_ADD:    dec_op = rrtq_pkg::OP_ADD;
			rrtq_pkg::KIND_SWITCH: dec_op = rrtq_pkg::OP_SWITCH;
			rrtq_pkg::KIND_TERM:   dec_op = rrtq_pkg::OP_TERM;
			default:               dec_op = rrtq_pkg::OP_NONE;
		endcase
	end

	assign pid_ext = {{PID_BITS{1'b0}}, task_pid};
	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign pop     = cmd_pop && (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]    <= dec_op;
			pid_q[wr_ptr_q]   <= pid_ext[PID_BITS-1:0];
			stack_q[wr_ptr_q] <= kernel_stack;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign cmd_ctl.valid = (cnt_q != 2'd0);
	assign cmd_ctl.op    = op_q[rd_ptr_q];
	assign cmd_pid       = pid_q[rd_ptr_q];
	assign cmd_stack     = stack_q[rd_ptr_q];

endmodule

@@ rtl/rrtq_back.sv @@
`timescale 1ns / 1ps

module rrtq_back #(
	parameter int MAX_TASKS = 16,
	parameter int PID_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rrtq_pkg::cmd_ctl_t               cmd_ctl,
	input  logic [PID_BITS-1:0]              cmd_pid,
	input  logic [rrtq_pkg::STACK_W-1:0]     cmd_stack,
	output logic                             cmd_pop,
	output logic                             done,
	output logic                             ok,
	output logic                             head_valid,
	output logic [rrtq_pkg::PID_PORT_W-1:0]  head_pid,
	output logic [rrtq_pkg::STACK_W-1:0]     head_stack,
	output logic [rrtq_pkg::CNT_W-1:0]       head_switches,
	output logic [rrtq_pkg::TOTAL_W-1:0]     task_total
);

	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int CNT_LO = 0;
	localparam int ST_LO  = rrtq_pkg::CNT_W;
	localparam int SK_LO  = ST_LO + rrtq_pkg::ST_W;
	localparam int PID_LO = SK_LO + rrtq_pkg::STACK_W;
	localparam int W      = PID_LO + PID_BITS;
	localparam logic [CW:0]   MAX_X   = (CW+1)'(MAX_TASKS);
	localparam logic [CW-1:0] MAX_C   = CW'(MAX_TASKS);
	localparam logic [IW-1:0] LAST_IX = IW'(MAX_TASKS - 1);

	rrtq_pkg::bk_state_t state_q, state_d;

	rrtq_pkg::op_t                 op_q;
	logic [PID_BITS-1:0]           pid_q;
	logic [rrtq_pkg::STACK_W-1:0]  stack_q;
	logic                          ok_q;
	logic [CW-1:0]                 len_q;
	logic [IW-1:0]                 head_q;
	logic [CW-1:0]                 off_q;
	logic [CW-1:0]                 src_q;
	logic                          pend_q;

	logic                          we;
	logic [IW-1:0]                 waddr;
	logic [W-1:0]                  wdata;
	logic [IW-1:0]                 raddr;
	logic [W-1:0]                  rdata;

	logic [PID_BITS-1:0]           r_pid;
	logic [rrtq_pkg::STACK_W-1:0]  r_stack;
	logic [rrtq_pkg::CNT_W-1:0]    r_cnt;
	logic [rrtq_pkg::CNT_W-1:0]    cnt_inc;
	logic [IW-1:0]                 head_nxt;
	logic                          rd_en;
	logic [PID_BITS+rrtq_pkg::PID_PORT_W-1:0] pid_out_ext;
	logic [CW+rrtq_pkg::TOTAL_W-1:0]          len_ext;

	function automatic logic [IW-1:0] phys(input logic [IW-1:0] hd, input logic [CW-1:0] off);
		logic [CW:0] s;
		s = {{(CW+1-IW){1'b0}}, hd} + {1'b0, off};
		if (s >= MAX_X) begin
			s = s - MAX_X;
		end
		return s[IW-1:0];
	endfunction

	rrtq_ram #(
		.WIDTH(W),
		.DEPTH(MAX_TASKS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign r_pid    = rdata[PID_LO +: PID_BITS];
	assign r_stack  = rdata[SK_LO +: rrtq_pkg::STACK_W];
	assign r_cnt    = rdata[CNT_LO +: rrtq_pkg::CNT_W];
	assign cnt_inc  = (r_cnt == '1) ? r_cnt : r_cnt + rrtq_pkg::CNT_W'(1);
	assign head_nxt = (head_q == LAST_IX) ? '0 : head_q + IW'(1);
	assign rd_en    = (off_q < len_q);

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		we      = 1'b0;
		waddr   = head_q;
		wdata   = rdata;
		raddr   = head_q;
		case (state_q)
			rrtq_pkg::S_IDLE: begin
				if (cmd_ctl.valid) begin
					cmd_pop = 1'b1;
					state_d = rrtq_pkg::S_EXEC;
				end
			end
			rrtq_pkg::S_EXEC: begin
				state_d = rrtq_pkg::S_HD_RD;
				case (op_q)
					rrtq_pkg::OP_ADD: begin
						if (len_q < MAX_C) begin
							we    = 1'b1;
							waddr = phys(head_q, len_q);
							wdata = {pid_q, stack_q, rrtq_pkg::ST_CREATED,
								{rrtq_pkg::CNT_W{1'b0}}};
						end
					end
					rrtq_pkg::OP_SWITCH: begin
						if (len_q != '0) begin
							state_d = rrtq_pkg::S_SW_WAIT;
						end
					end
					rrtq_pkg::OP_TERM: begin
						if (len_q != '0) begin
							state_d = rrtq_pkg::S_TM_SRCH;
						end
					end
					default: state_d = rrtq_pkg::S_HD_RD;
				endcase
			end
			rrtq_pkg::S_SW_WAIT: begin
				we      = 1'b1;
				waddr   = phys(head_q, len_q);
				wdata   = {r_pid, r_stack, rrtq_pkg::ST_RUNNABLE, r_cnt};
				state_d = rrtq_pkg::S_SW_RD2;
			end
			rrtq_pkg::S_SW_RD2: begin
				state_d = rrtq_pkg::S_SW_WAIT2;
			end
			rrtq_pkg::S_SW_WAIT2: begin
				we      = 1'b1;
				wdata   = {r_pid, r_stack, rrtq_pkg::ST_RUNNING, cnt_inc};
				state_d = rrtq_pkg::S_HD_RD;
			end
			rrtq_pkg::S_TM_SRCH: begin
				raddr = phys(head_q, off_q);
				if (pend_q && (r_pid == pid_q)) begin
					state_d = rrtq_pkg::S_TM_MOVE;
				end else if (pend_q && (src_q == '0)) begin
					state_d = rrtq_pkg::S_HD_RD;
				end
			end
			rrtq_pkg::S_TM_MOVE: begin
				raddr = phys(head_q, off_q);
				we    = pend_q;
				waddr = phys(head_q, src_q - CW'(1));
				if (!rd_en) begin
					state_d = rrtq_pkg::S_HD_RD;
				end
			end
			rrtq_pkg::S_HD_RD: begin
				state_d = rrtq_pkg::S_HD_OUT;
			end
			rrtq_pkg::S_HD_OUT: begin
				state_d = rrtq_pkg::S_IDLE;
			end
			default: state_d = rrtq_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrtq_pkg::S_IDLE;
			len_q   <= '0;
			head_q  <= '0;
			off_q   <= '0;
			src_q   <= '0;
			pend_q  <= 1'b0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= (state_q == rrtq_pkg::S_HD_OUT);
			case (state_q)
				rrtq_pkg::S_EXEC: begin
					pend_q <= 1'b0;
					off_q  <= len_q - CW'(1);
					if ((op_q == rrtq_pkg::OP_ADD) && (len_q < MAX_C)) begin
						len_q <= len_q + CW'(1);
					end
				end
				rrtq_pkg::S_SW_WAIT: begin
					head_q <= head_nxt;
				end
				rrtq_pkg::S_TM_SRCH: begin
					if (pend_q && (r_pid == pid_q)) begin
						off_q  <= src_q + CW'(1);
						pend_q <= 1'b0;
					end else begin
						pend_q <= 1'b1;
						src_q  <= off_q;
						off_q  <= off_q - CW'(1);
					end
				end
				rrtq_pkg::S_TM_MOVE: begin
					pend_q <= rd_en;
					src_q  <= off_q;
					off_q  <= off_q + CW'(1);
					if (!rd_en) begin
						len_q <= len_q - CW'(1);
					end
				end
				default: begin
					pend_q <= pend_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rrtq_pkg::S_IDLE: begin
				op_q    <= cmd_ctl.op;
				pid_q   <= cmd_pid;
				stack_q <= cmd_stack;
				ok_q    <= 1'b0;
			end
			rrtq_pkg::S_EXEC: begin
				ok_q <= (op_q == rrtq_pkg::OP_ADD) && (len_q < MAX_C);
			end
			rrtq_pkg::S_SW_WAIT2: begin
				ok_q <= 1'b1;
			end
			rrtq_pkg::S_TM_MOVE: begin
				ok_q <= 1'b1;
			end
			default: begin
				ok_q <= ok_q;
			end
		endcase
	end

	assign pid_out_ext = {{rrtq_pkg::PID_PORT_W{1'b0}}, r_pid};
	assign len_ext     = {{rrtq_pkg::TOTAL_W{1'b0}}, len_q};

	always_ff @(posedge clk) begin
		if (state_q == rrtq_pkg::S_HD_OUT) begin
			ok         <= ok_q;
			head_valid <= (len_q != '0);
			task_total <= len_ext[rrtq_pkg::TOTAL_W-1:0];
			if (len_q != '0) begin
				head_pid      <= pid_out_ext[rrtq_pkg::PID_PORT_W-1:0];
				head_stack    <= r_stack;
				head_switches <= r_cnt;
			end else begin
				head_pid      <= '0;
				head_stack    <= '0;
				head_switches <= '0;
			end
		end
	end

endmodule

@@ rtl/round_robin_task_queue.sv @@
`timescale 1ns / 1ps
// channel   handshake            fields
// request   start in, busy out   kind, task_pid, kernel_stack
// result    done out (strobe)    ok, head_valid, head_pid, head_stack, head_switches, task_total
//
// Add, unknown kind, and switch or terminate on an empty queue go from accept through EXEC,
// HD_RD and HD_OUT to done; switch adds SW_WAIT, SW_RD2 and SW_WAIT2 before HD_RD; terminate
// searches from the tail (TM_SRCH) and, if the pid is found, moves later entries down (TM_MOVE).
// The task RAM (one registered read, one write a cycle) sets these steps.
// A two-entry request queue keeps taking requests while the executor works, until it is full (busy).
// arst_n empties the queue; the task RAM needs no clearing. done cannot be held off.
module round_robin_task_queue #(
	parameter int MAX_TASKS = 16,
	parameter int PID_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [rrtq_pkg::KIND_W-1:0]      kind,
	input  logic [rrtq_pkg::PID_PORT_W-1:0]  task_pid,
	input  logic [rrtq_pkg::STACK_W-1:0]     kernel_stack,
	output logic                             done,
	output logic                             ok,
	output logic                             head_valid,
	output logic [rrtq_pkg::PID_PORT_W-1:0]  head_pid,
	output logic [rrtq_pkg::STACK_W-1:0]     head_stack,
	output logic [rrtq_pkg::CNT_W-1:0]       head_switches,
	output logic [rrtq_pkg::TOTAL_W-1:0]     task_total
);

	rrtq_pkg::cmd_ctl_t            cmd_ctl;
	logic [PID_BITS-1:0]           cmd_pid;
	logic [rrtq_pkg::STACK_W-1:0]  cmd_stack;
	logic                          cmd_pop;

	rrtq_front #(
		.PID_BITS(PID_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.task_pid    (task_pid),
		.kernel_stack(kernel_stack),
		.cmd_ctl     (cmd_ctl),
		.cmd_pid     (cmd_pid),
		.cmd_stack   (cmd_stack),
		.cmd_pop     (cmd_pop)
	);

	rrtq_back #(
		.MAX_TASKS(MAX_TASKS),
		.PID_BITS (PID_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_ctl      (cmd_ctl),
		.cmd_pid      (cmd_pid),
		.cmd_stack    (cmd_stack),
		.cmd_pop      (cmd_pop),
		.done         (done),
		.ok           (ok),
		.head_valid   (head_valid),
		.head_pid     (head_pid),
		.head_stack   (head_stack),
		.head_switches(head_switches),
		.task_total   (task_total)
	);

`ifndef SYNTH
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_empty_head_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !head_valid) |-> (head_pid == '0 && head_stack == '0 &&
			head_switches == '0 && task_total == '0))
		else $error("empty queue reported nonzero head or total");

	a_pop_only_when_queued: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_ctl.valid)
		else $error("executor took a request from an empty queue");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_T = 16;
	localparam logic [rrtq_pkg::KIND_W-1:0] KIND_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 50;
	localparam int RANDOM_ITEMS = 1200;

	typedef struct packed {
		logic [rrtq_pkg::KIND_W-1:0]     kind;
		logic [rrtq_pkg::PID_PORT_W-1:0] pid;
		logic [rrtq_pkg::STACK_W-1:0]    stack;
		logic                            hold;
	} task_req_t;

	typedef struct packed {
		logic                            ok;
		logic                            head_valid;
		logic [rrtq_pkg::PID_PORT_W-1:0] head_pid;
		logic [rrtq_pkg::STACK_W-1:0]    head_stack;
		logic [rrtq_pkg::CNT_W-1:0]      head_switches;
		logic [rrtq_pkg::TOTAL_W-1:0]    task_total;
	} head_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [rrtq_pkg::KIND_W-1:0] kind = '0;
	logic [rrtq_pkg::PID_PORT_W-1:0] task_pid = '0;
	logic [rrtq_pkg::STACK_W-1:0] kernel_stack = '0;
	logic busy;
	logic done;
	logic ok;
	logic head_valid;
	logic [rrtq_pkg::PID_PORT_W-1:0] head_pid;
	logic [rrtq_pkg::STACK_W-1:0] head_stack;
	logic [rrtq_pkg::CNT_W-1:0] head_switches;
	logic [rrtq_pkg::TOTAL_W-1:0] task_total;

	round_robin_task_queue #(.MAX_TASKS(MAX_T), .PID_BITS(16)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.task_pid(task_pid),
		.kernel_stack(kernel_stack),
		.done(done),
		.ok(ok),
		.head_valid(head_valid),
		.head_pid(head_pid),
		.head_stack(head_stack),
		.head_switches(head_switches),
		.task_total(task_total)
	);

	always #5 clk = ~clk;

	// shadow of the ready queue, slot 0 is the head
	logic [rrtq_pkg::PID_PORT_W-1:0] sh_pid [MAX_T];
	logic [rrtq_pkg::STACK_W-1:0]    sh_stack [MAX_T];
	logic [rrtq_pkg::ST_W-1:0]       sh_status [MAX_T];
	logic [rrtq_pkg::CNT_W-1:0]      sh_count [MAX_T];
	int                              sh_len = 0;

	task_req_t    pending_reqs[$];
	head_report_t expected_heads[$];
	task_req_t    cur_req;
	int           total_reqs = 0;
	int           accepted_reqs = 0;
	int           errors = 0;
	int           shown = 0;
	int           cycles = 0;
	int           gap_left = 0;
	int           burst_left = 1;

	task automatic move_slot(input int dst, input int src);
		sh_pid[dst] = sh_pid[src];
		sh_stack[dst] = sh_stack[src];
		sh_status[dst] = sh_status[src];
		sh_count[dst] = sh_count[src];
	endtask

	task automatic schedule_request(input task_req_t r, output head_report_t e);
		logic [rrtq_pkg::PID_PORT_W-1:0] p;
		logic [rrtq_pkg::STACK_W-1:0] s;
		logic [rrtq_pkg::CNT_W-1:0] c;
		int hit;
		logic found;
		logic good;
		good = 1'b0;
		case (r.kind)
			rrtq_pkg::KIND_ADD: begin
				if (sh_len < MAX_T) begin
					sh_pid[sh_len] = r.pid;
					sh_stack[sh_len] = r.stack;
					sh_status[sh_len] = rrtq_pkg::ST_CREATED;
					sh_count[sh_len] = '0;
					sh_len++;
					good = 1'b1;
				end
			end
			rrtq_pkg::KIND_SWITCH: begin
				if (sh_len > 0) begin
					p = sh_pid[0];
					s = sh_stack[0];
					c = sh_count[0];
					for (int i = 0; i < sh_len - 1; i++)
						move_slot(i, i + 1);
					sh_pid[sh_len-1] = p;
					sh_stack[sh_len-1] = s;
					sh_count[sh_len-1] = c;
					sh_status[sh_len-1] = rrtq_pkg::ST_RUNNABLE;
					sh_status[0] = rrtq_pkg::ST_RUNNING;
					if (sh_count[0] != '1)
						sh_count[0] = sh_count[0] + 1'b1;
					good = 1'b1;
				end
			end
			rrtq_pkg::KIND_TERM: begin
				found = 1'b0;
				hit = 0;
				for (int i = 0; i < sh_len; i++)
					if (sh_pid[i] == r.pid) begin
						hit = i;
						found = 1'b1;
					end
				if (found) begin
					for (int i = hit; i + 1 < sh_len; i++)
						move_slot(i, i + 1);
					sh_len--;
					good = 1'b1;
				end
			end
			default: good = 1'b0;
		endcase
		e.ok = good;
		e.task_total = rrtq_pkg::TOTAL_W'(sh_len);
		if (sh_len > 0) begin
			e.head_valid = 1'b1;
			e.head_pid = sh_pid[0];
			e.head_stack = sh_stack[0];
			e.head_switches = sh_count[0];
		end else begin
			e.head_valid = 1'b0;
			e.head_pid = '0;
			e.head_stack = '0;
			e.head_switches = '0;
		end
	endtask

	task automatic queue_req(input logic [rrtq_pkg::KIND_W-1:0] k,
			input logic [rrtq_pkg::PID_PORT_W-1:0] p,
			input logic [rrtq_pkg::STACK_W-1:0] s, input logic h);
		task_req_t r;
		r.kind = k;
		r.pid = p;
		r.stack = s;
		r.hold = h;
		pending_reqs.push_back(r);
		total_reqs++;
	endtask

	function automatic logic [rrtq_pkg::STACK_W-1:0] rand_stack();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {16'($urandom), 32'($urandom)};
		endcase
	endfunction

	function automatic logic [rrtq_pkg::PID_PORT_W-1:0] rand_pid();
		if ($urandom_range(0, 99) < 85)
			return rrtq_pkg::PID_PORT_W'($urandom_range(0, 23));
		return rrtq_pkg::PID_PORT_W'($urandom);
	endfunction

	// driver
	always @(posedge clk) begin
		head_report_t e;
		task_req_t nxt;
		if (arst_n) begin
			if (start && !busy) begin
				schedule_request(cur_req, e);
				expected_heads.push_back(e);
				accepted_reqs++;
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_reqs.size() > 0 &&
						(!pending_reqs[0].hold || expected_heads.size() == 0)) begin
					nxt = pending_reqs.pop_front();
					cur_req <= nxt;
					start <= 1'b1;
					kind <= nxt.kind;
					task_pid <= nxt.pid;
					kernel_stack <= nxt.stack;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
					end else begin
						burst_left--;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		head_report_t got;
		head_report_t e;
		if (arst_n && done) begin
			got = {ok, head_valid, head_pid, head_stack, head_switches, task_total};
			if (expected_heads.size() == 0) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("unexpected result: ok=%0d hv=%0d pid=%h stack=%h sw=%0d total=%0d",
						got.ok, got.head_valid, got.head_pid, got.head_stack,
						got.head_switches, got.task_total);
				end
			end else begin
				e = expected_heads.pop_front();
				if (got.ok !== e.ok || got.head_valid !== e.head_valid ||
						got.head_pid !== e.head_pid || got.head_stack !== e.head_stack ||
						got.head_switches !== e.head_switches ||
						got.task_total !== e.task_total) begin
					errors++;
					if (shown < 10) begin
						shown++;
						$display("mismatch exp: ok=%0d hv=%0d pid=%h stack=%h sw=%0d total=%0d",
							e.ok, e.head_valid, e.head_pid, e.head_stack,
							e.head_switches, e.task_total);
						$display("         got: ok=%0d hv=%0d pid=%h stack=%h sw=%0d total=%0d",
							got.ok, got.head_valid, got.head_pid, got.head_stack,
							got.head_switches, got.task_total);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int phase;
		int phase_len;
		int pick;
		int add_w;
		int sw_w;
		int term_w;
		int made;
		logic [rrtq_pkg::KIND_W-1:0] k;

		// empty queue cases
		queue_req(rrtq_pkg::KIND_SWITCH, 16'h0000, '0, 1'b0);
		queue_req(rrtq_pkg::KIND_TERM, 16'h0005, '0, 1'b0);
		queue_req(KIND_NONE, 16'h0000, '0, 1'b0);
		// single task rotates onto itself
		queue_req(rrtq_pkg::KIND_ADD, 16'h0000, '0, 1'b0);
		queue_req(rrtq_pkg::KIND_SWITCH, 16'h0000, '0, 1'b0);
		queue_req(rrtq_pkg::KIND_SWITCH, 16'h0000, '0, 1'b0);
		queue_req(rrtq_pkg::KIND_ADD, 16'hFFFF, '1, 1'b0);
		// duplicate pid, terminate takes the one nearest the tail
		queue_req(rrtq_pkg::KIND_ADD, 16'h0000, 48'h1234_5678_9ABC, 1'b0);
		queue_req(rrtq_pkg::KIND_SWITCH, 16'hFFFF, '1, 1'b0);
		queue_req(rrtq_pkg::KIND_SWITCH, 16'h0000, '0, 1'b0);
		queue_req(rrtq_pkg::KIND_TERM, 16'h0000, '1, 1'b0);
		queue_req(rrtq_pkg::KIND_TERM, 16'hBEEF, '0, 1'b0);
		queue_req(KIND_NONE, 16'hFFFF, '1, 1'b0);
		queue_req(rrtq_pkg::KIND_ADD, 16'h0007, 48'hAAAA_AAAA_AAAA, 1'b0);
		queue_req(rrtq_pkg::KIND_ADD, 16'h0009, 48'h5555_5555_5555, 1'b0);
		// tail, then head, then the rest
		queue_req(rrtq_pkg::KIND_TERM, 16'h0009, '0, 1'b0);
		queue_req(rrtq_pkg::KIND_TERM, 16'h0000, '0, 1'b0);
		queue_req(rrtq_pkg::KIND_TERM, 16'hFFFF, '0, 1'b0);
		queue_req(rrtq_pkg::KIND_SWITCH, 16'h0000, '0, 1'b0);
		queue_req(rrtq_pkg::KIND_TERM, 16'h0007, '0, 1'b0);
		queue_req(rrtq_pkg::KIND_SWITCH, 16'h0000, '0, 1'b0);

		made = 0;
		while (made < RANDOM_ITEMS) begin
			phase = $urandom_range(0, 2);
			phase_len = $urandom_range(20, 80);
			case (phase)
				0: begin add_w = 60; sw_w = 25; term_w = 10; end
				1: begin add_w = 15; sw_w = 25; term_w = 55; end
				default: begin add_w = 35; sw_w = 35; term_w = 25; end
			endcase
			for (int i = 0; i < phase_len; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < add_w)
					k = rrtq_pkg::KIND_ADD;
				else if (pick < add_w + sw_w)
					k = rrtq_pkg::KIND_SWITCH;
				else if (pick < add_w + sw_w + term_w)
					k = rrtq_pkg::KIND_TERM;
				else
					k = KIND_NONE;
				queue_req(k, rand_pid(), rand_stack(), (made % 150) == 0);
				made++;
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_reqs < total_reqs || expected_heads.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
